[design/atph_pkg.sv]
// Shared types, register codes and constants for the adaptive transmit power block.
// No dependencies; every other design file imports this package.
`default_nettype none

package atph_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_ECO_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_ADAPT_ENABLE  = 3'd1;
    localparam logic [2:0] CFG_STABLE_TIME   = 3'd2;
    localparam logic [2:0] CFG_EVAL_INTERVAL = 3'd3;
    localparam logic [2:0] CFG_STEP_DOWN_TH  = 3'd4;
    localparam logic [2:0] CFG_REDUCE_TH     = 3'd5;
    localparam logic [2:0] CFG_RESTORE_TH    = 3'd6;

    localparam logic [31:0]       STABLE_TIME_RST   = 32'd30000;
    localparam logic [31:0]       EVAL_INTERVAL_RST = 32'd10000;
    localparam logic signed [7:0] STEP_DOWN_TH_RST  = -8'sd60;
    localparam logic signed [7:0] REDUCE_TH_RST     = -8'sd53;
    localparam logic signed [7:0] RESTORE_TH_RST    = -8'sd67;

    localparam logic [6:0] PWR_FULL    = 7'd78;
    localparam logic [6:0] PWR_MEDIUM  = 7'd60;
    localparam logic [6:0] PWR_REDUCED = 7'd44;

    typedef enum logic [1:0] {
        LVL_FULL    = 2'd0,
        LVL_MEDIUM  = 2'd1,
        LVL_REDUCED = 2'd2
    } t_level;

    typedef struct packed {
        logic [31:0]       now_ms;
        logic              link_up;
        logic [31:0]       link_since_ms;
        logic signed [7:0] signal_dbm;
        logic              apply_ok;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  level;
        logic [6:0]  power_quarter_dbm;
        logic        change_requested;
        logic        fault;
        logic [15:0] change_count;
        logic [15:0] error_count;
    } t_out_word;

    typedef struct packed {
        logic              eco_enable;
        logic              adaptive_enable;
        logic [31:0]       stable_time_ms;
        logic [31:0]       eval_interval_ms;
        logic signed [7:0] step_down_threshold;
        logic signed [7:0] reduce_threshold;
        logic signed [7:0] restore_threshold;
    } t_cfg;

    function automatic logic [6:0] level_power(input t_level lvl);
        logic [6:0] pwr;
        unique case (lvl)
            LVL_MEDIUM:  pwr = PWR_MEDIUM;
            LVL_REDUCED: pwr = PWR_REDUCED;
            default:     pwr = PWR_FULL;
        endcase
        return pwr;
    endfunction

endpackage

`default_nettype wire

[design/atph_cfg.sv]
// Configuration register file: seven registers written through a valid-qualified port.
// Depends on atph_pkg for register codes, reset values and the t_cfg struct.
`default_nettype none

module atph_cfg
    import atph_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eco_enable          <= 1'b0;
            r_cfg.adaptive_enable     <= 1'b0;
            r_cfg.stable_time_ms      <= STABLE_TIME_RST;
            r_cfg.eval_interval_ms    <= EVAL_INTERVAL_RST;
            r_cfg.step_down_threshold <= STEP_DOWN_TH_RST;
            r_cfg.reduce_threshold    <= REDUCE_TH_RST;
            r_cfg.restore_threshold   <= RESTORE_TH_RST;
        end else if (i_cfg_valid) begin
            // indexes past the list are dropped
            unique case (i_cfg_index)
                CFG_ECO_ENABLE:    r_cfg.eco_enable          <= i_cfg_data[0];
                CFG_ADAPT_ENABLE:  r_cfg.adaptive_enable     <= i_cfg_data[0];
                CFG_STABLE_TIME:   r_cfg.stable_time_ms      <= i_cfg_data;
                CFG_EVAL_INTERVAL: r_cfg.eval_interval_ms    <= i_cfg_data;
                CFG_STEP_DOWN_TH:  r_cfg.step_down_threshold <= i_cfg_data[7:0];
                CFG_REDUCE_TH:     r_cfg.reduce_threshold    <= i_cfg_data[7:0];
                CFG_RESTORE_TH:    r_cfg.restore_threshold   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[design/atph_step.sv]
// Evaluation pass and controller state: level, last evaluation time, fault, counters.
// Depends on atph_pkg for the word structs, t_cfg and the level codes.
`default_nettype none

module atph_step
    import atph_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire t_in_word i_word,
    input  wire t_cfg     i_cfg,
    output t_out_word     o_word
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    t_level                 r_level,  n_level;
    logic [31:0]            r_last,   n_last;
    logic                   r_fault,  n_fault;
    logic [COUNT_WIDTH-1:0] r_chg,    n_chg;
    logic [COUNT_WIDTH-1:0] r_err,    n_err;

    logic        tried;
    logic        forced;
    logic        ready;
    t_level      target;
    logic [31:0] up_time;
    logic [31:0] since_eval;
    logic [31:0] chg_wide;
    logic [31:0] err_wide;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc1(input logic [COUNT_WIDTH-1:0] c);
        return (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc2(input logic [COUNT_WIDTH-1:0] c);
        return (c >= CNT_MAX - COUNT_WIDTH'(1)) ? CNT_MAX : c + COUNT_WIDTH'(2);
    endfunction

    always_comb begin
        n_level    = r_level;
        n_last     = r_last;
        n_fault    = r_fault;
        n_chg      = r_chg;
        n_err      = r_err;
        tried      = 1'b0;
        target     = r_level;
        up_time    = i_word.now_ms - i_word.link_since_ms;
        since_eval = i_word.now_ms - r_last;
        forced     = !i_cfg.eco_enable || !i_cfg.adaptive_enable || r_fault;
        ready      = (i_word.link_since_ms != 32'd0)
                     && (up_time >= i_cfg.stable_time_ms)
                     && (since_eval >= i_cfg.eval_interval_ms);

        unique case (r_level)
            LVL_MEDIUM: begin
                if (i_word.signal_dbm >= i_cfg.reduce_threshold)
                    target = LVL_REDUCED;
                else if (i_word.signal_dbm <= i_cfg.restore_threshold)
                    target = LVL_FULL;
            end
            LVL_REDUCED: begin
                if (i_word.signal_dbm <= i_cfg.restore_threshold)
                    target = LVL_FULL;
                else if (i_word.signal_dbm <= i_cfg.step_down_threshold)
                    target = LVL_MEDIUM;
            end
            default: begin
                if (i_word.signal_dbm >= i_cfg.step_down_threshold)
                    target = LVL_MEDIUM;
            end
        endcase

        if (i_word.link_up) begin
            if (forced) begin
                if (r_level != LVL_FULL) begin
                    tried = 1'b1;
                    if (i_word.apply_ok) begin
                        n_level = LVL_FULL;
                        n_chg   = sat_inc1(r_chg);
                    end else begin
                        n_err   = sat_inc1(r_err);
                        n_fault = 1'b1;
                    end
                end
            end else if (ready) begin
                n_last = i_word.now_ms;
                if (target != r_level) begin
                    tried = 1'b1;
                    if (i_word.apply_ok) begin
                        n_level = target;
                        n_chg   = sat_inc1(r_chg);
                    end else begin
                        // refused step; from a lower level the fallback to full fails the same way and counts too
                        n_fault = 1'b1;
                        n_err   = (r_level != LVL_FULL) ? sat_inc2(r_err) : sat_inc1(r_err);
                    end
                end
            end
        end

        chg_wide = 32'(n_chg);
        err_wide = 32'(n_err);

        o_word.level             = n_level;
        o_word.power_quarter_dbm = level_power(n_level);
        o_word.change_requested  = tried;
        o_word.fault             = n_fault;
        o_word.change_count      = chg_wide[15:0];
        o_word.error_count       = err_wide[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LVL_FULL;
            r_last  <= 32'd0;
            r_fault <= 1'b0;
            r_chg   <= '0;
            r_err   <= '0;
        end else if (i_adv) begin
            r_level <= n_level;
            r_last  <= n_last;
            r_fault <= n_fault;
            r_chg   <= n_chg;
            r_err   <= n_err;
        end
    end

    // fault only clears by reset
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("fault latch cleared without reset");

    // counters never go backwards
    a_chg_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_chg >= $past(r_chg)) && (r_err >= $past(r_err)))
        else $error("counter decreased");

    // state moves only when a word is evaluated
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_level) && $stable(r_last) && $stable(r_chg))
        else $error("state changed without an evaluated word");

endmodule

`default_nettype wire

[design/adaptive_tx_power_hysteresis.sv]
// Adaptive transmit power controller with hysteresis: top level and handshake stages.
// Depends on atph_pkg, atph_cfg and atph_step.
//
// One word goes in per cycle while the output does not stall, and one result word
// comes out for each: the word is captured in an input register, evaluated in a
// single combinational pass against the held controller state, and the result is
// written to an output register in the same edge that updates the state. Throughput
// is therefore one word per clock, set by the state feedback loop; a stall on the
// output backs up into the input register and then onto o_in_stall. Configuration
// writes are always taken (o_cfg_ready is tied high); write them only while no word
// is in flight. Counters saturate at 2^COUNT_WIDTH - 1 and report their low 16 bits.
`default_nettype none

module adaptive_tx_power_hysteresis
    import atph_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire t_in_word    i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_word        o_out_data,
    input  wire logic        i_out_stall,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      adv;
    t_cfg      cfg;
    t_out_word step_word;

    assign o_cfg_ready = 1'b1;

    atph_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // held word moves on when the result register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    atph_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_word  (r_in_word),
        .i_cfg   (cfg),
        .o_word  (step_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_word <= step_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with a free stage");

    a_fill_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("held word did not reach the result register");

    a_fill_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted word not held");

endmodule

`default_nettype wire
